>>> hdl/dfqs_pkg.sv
// ----------------------------------------------------------------------------
// Deduplicating FIFO queue package
// Shared widths, command and status codes, state type and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package dfqs_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ID_WIDTH  = 16;
  localparam int unsigned ID_PORT_W = 16;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REM = 2'd2,
    CMD_POS = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DONE     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_BADID    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/dfqs_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one slot; compares it with the search key, takes the neighbour's
// slot on a shift, or loads a new identifier at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module dfqs_cell #(
  parameter int unsigned IdWidth = dfqs_pkg::ID_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dfqs_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic [IdWidth-1:0]      key_i,
  input  wire logic                    nbr_valid_i,
  input  wire logic [IdWidth-1:0]      nbr_id_i,
  output logic                         valid_o,
  output logic [IdWidth-1:0]           id_o,
  output logic                         match_o
);

  logic               valid_q, valid_d;
  logic [IdWidth-1:0] id_q, id_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    if (ctrl_i.shift) begin
      valid_d = nbr_valid_i;
      id_d    = nbr_id_i;
    end else if (ctrl_i.load) begin
      valid_d = 1'b1;
      id_d    = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign match_o = valid_q && (id_q == key_i);

endmodule

`default_nettype wire

>>> hdl/dedup_fifo_queue_with_search_top.sv
// ----------------------------------------------------------------------------
// Deduplicating FIFO queue with search and remove
// Ordered queue of unique nonzero identifiers held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: cmd_i and patient_id_i are taken at a rising edge with
//   start high and busy low. busy stays high while the command is worked on.
//   Result channel: done_o marks one cycle in which status_o, out_id_o,
//   position_o and occupancy_o hold the result; the receiver cannot stall it.
//   Steps: the accepting edge registers the command, the search state
//   registers the hit flag and the match index encoded from all cells, and
//   the apply state shifts or loads the cells and registers the result.
//   The block takes no new command until the previous result is shown;
//   the next command may be taken in the cycle in which the previous
//   result is shown.
//   Every cell compares its slot with the key in parallel, and a removal
//   shifts all later cells up by one at once.
//   Reset: the queue is empty, busy and done_o are low.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_fifo_queue_with_search_top #(
  parameter int unsigned Depth   = dfqs_pkg::DEPTH,
  parameter int unsigned IdWidth = dfqs_pkg::ID_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [dfqs_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [dfqs_pkg::ID_PORT_W-1:0]  patient_id_i,
  output logic                                 done_o,
  output logic [dfqs_pkg::STATUS_W-1:0]        status_o,
  output logic [dfqs_pkg::ID_PORT_W-1:0]       out_id_o,
  output logic [dfqs_pkg::POS_W-1:0]           position_o,
  output logic [dfqs_pkg::POS_W-1:0]           occupancy_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dfqs_pkg::state_e  state_q, state_d;
  dfqs_pkg::cmd_e    cmd_q;
  logic [IdWidth-1:0] key_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              hit_q;
  logic [IdxW-1:0]   k_q;
  logic [IdxW-1:0]   k_enc;

  logic              shift_req;
  logic [IdxW-1:0]   shift_k;
  logic              load_req;

  logic                          done_q, done_d;
  dfqs_pkg::status_e             status_q, status_d;
  logic [IdWidth-1:0]            oid_q, oid_d;
  logic [CntW-1:0]               pos_q, pos_d;

  logic                          accept;

  logic                          cell_valid [Depth+1];
  logic [IdWidth-1:0]            cell_id    [Depth+1];
  logic [Depth-1:0]              match;
  dfqs_pkg::cell_ctrl_t          cell_ctrl  [Depth];

  assign accept = start && !busy;
  assign busy   = (state_q != dfqs_pkg::S_IDLE);

  // tail neighbour of the last cell is always empty
  assign cell_valid[Depth] = 1'b0;
  assign cell_id[Depth]    = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    assign cell_ctrl[g].shift = shift_req && (IdxW'(g) >= shift_k);
    assign cell_ctrl[g].load  = load_req && (CntW'(g) == count_q);

    dfqs_cell #(
      .IdWidth (IdWidth)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[g]),
      .key_i       (key_q),
      .nbr_valid_i (cell_valid[g+1]),
      .nbr_id_i    (cell_id[g+1]),
      .valid_o     (cell_valid[g]),
      .id_o        (cell_id[g]),
      .match_o     (match[g])
    );
  end

  // identifiers are unique, so at most one match bit is set
  always_comb begin
    k_enc = '0;
    for (int i = 0; i < Depth; i++) begin
      if (match[i]) begin
        k_enc = k_enc | IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    shift_req = 1'b0;
    shift_k   = k_q;
    load_req  = 1'b0;
    done_d    = 1'b0;
    status_d  = status_q;
    oid_d     = oid_q;
    pos_d     = pos_q;
    case (state_q)
      dfqs_pkg::S_IDLE: begin
        if (accept) begin
          state_d = dfqs_pkg::S_SEARCH;
        end
      end
      dfqs_pkg::S_SEARCH: begin
        state_d = dfqs_pkg::S_APPLY;
      end
      dfqs_pkg::S_APPLY: begin
        state_d = dfqs_pkg::S_IDLE;
        done_d  = 1'b1;
        oid_d   = '0;
        pos_d   = '0;
        if (cmd_q == dfqs_pkg::CMD_DEQ) begin
          if (count_q == '0) begin
            status_d = dfqs_pkg::ST_EMPTY;
          end else begin
            status_d  = dfqs_pkg::ST_DONE;
            oid_d     = cell_id[0];
            pos_d     = CntW'(1);
            shift_req = 1'b1;
            shift_k   = '0;
            count_d   = count_q - CntW'(1);
          end
        end else if (key_q == '0) begin
          status_d = dfqs_pkg::ST_BADID;
        end else if (cmd_q == dfqs_pkg::CMD_ENQ) begin
          if (count_q >= CntW'(Depth)) begin
            status_d = dfqs_pkg::ST_FULL;
          end else if (hit_q) begin
            status_d = dfqs_pkg::ST_PRESENT;
            oid_d    = key_q;
            pos_d    = CntW'(k_q) + CntW'(1);
          end else begin
            status_d = dfqs_pkg::ST_ADDED;
            oid_d    = key_q;
            pos_d    = count_q + CntW'(1);
            load_req = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end else if (!hit_q) begin
          status_d = dfqs_pkg::ST_NOTFOUND;
        end else begin
          status_d = dfqs_pkg::ST_DONE;
          oid_d    = key_q;
          pos_d    = CntW'(k_q) + CntW'(1);
          if (cmd_q == dfqs_pkg::CMD_REM) begin
            shift_req = 1'b1;
            count_d   = count_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = dfqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfqs_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= dfqs_pkg::cmd_e'(cmd_i);
      key_q <= IdWidth'(patient_id_i);
    end
    if (state_q == dfqs_pkg::S_SEARCH) begin
      hit_q <= |match;
      k_q   <= k_enc;
    end
    status_q <= status_d;
    oid_q    <= oid_d;
    pos_q    <= pos_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_id_o    = dfqs_pkg::ID_PORT_W'(oid_q);
  assign position_o  = dfqs_pkg::POS_W'(pos_q);
  assign occupancy_o = dfqs_pkg::POS_W'(count_q);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("occupancy above depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted command did not raise busy");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("identifier held in more than one cell");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> cell_valid[0])
    else $error("head cell empty with nonzero occupancy");

endmodule

`default_nettype wire
